>>> sv/relay_reservation_quota_table_core_defines.svh
// Assertion macros used by the checker file
`ifndef RELAY_RESERVATION_QUOTA_TABLE_CORE_DEFINES_SVH
`define RELAY_RESERVATION_QUOTA_TABLE_CORE_DEFINES_SVH

// Check an implication on every rising clock edge outside reset
`define RRQT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a next-cycle implication outside reset
`define RRQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/rrqt_pkg.sv
// ----------------------------------------------------------------------------
// rrqt_pkg
// Types, codes and constants of the relay reservation quota table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrqt_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int QDEPTH   = 2;

    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] M40 = 40'hFF_FFFF_FFFF;

    // Transaction kinds
    localparam logic [2:0] K_RESERVE = 3'd0;
    localparam logic [2:0] K_FORWARD = 3'd1;
    localparam logic [2:0] K_ADD     = 3'd2;
    localparam logic [2:0] K_CLOSE   = 3'd3;
    localparam logic [2:0] K_LOOKUP  = 3'd4;

    // Status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NO_ID     = 4'd1;
    localparam logic [3:0] ST_FORBID    = 4'd2;
    localparam logic [3:0] ST_ID_CAP    = 4'd3;
    localparam logic [3:0] ST_GRP_CAP   = 4'd4;
    localparam logic [3:0] ST_TOT_CAP   = 4'd5;
    localparam logic [3:0] ST_EXPIRED   = 4'd6;
    localparam logic [3:0] ST_CONN_CEIL = 4'd7;
    localparam logic [3:0] ST_BYTE_CEIL = 4'd8;
    localparam logic [3:0] ST_NOT_FOUND = 4'd9;

    // Register indexes
    localparam logic [2:0] R_MAX_ID   = 3'd0;
    localparam logic [2:0] R_MAX_GRP  = 3'd1;
    localparam logic [2:0] R_MAX_TOT  = 3'd2;
    localparam logic [2:0] R_TTL      = 3'd3;
    localparam logic [2:0] R_IDLE     = 3'd4;
    localparam logic [2:0] R_BLIMIT   = 3'd5;
    localparam logic [2:0] R_CLIMIT   = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] identity;
        logic        identity_present;
        logic [63:0] group;
        logic        group_present;
        logic        endpoint_forbidden;
        logic [11:0] handle_in;
        logic [39:0] byte_count;
        logic [47:0] now;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] handle_out;
        logic [47:0] expiry;
        logic [39:0] used_bytes;
        logic [15:0] conn_count;
        logic [63:0] total_forwarded;
        logic [31:0] active_forwards;
    } t_out;

    // Classified transaction passed from front to back
    typedef struct packed {
        t_in         item;
        logic        sweep;       // reserve or forward: sweep first
        logic        early_fail;  // reserve rejected before the cap checks
        logic [3:0]  early_st;
        logic [SLOT_W-1:0] slot;
        logic        slot_ok;     // handle slot index in range
    } t_cmd;

    typedef struct packed {
        logic [4:0]  max_id;
        logic [4:0]  max_grp;
        logic [4:0]  max_tot;
        logic [31:0] ttl;
        logic [31:0] idle;
        logic [39:0] blimit;
        logic [15:0] climit;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/rrqt_front.sv
// ----------------------------------------------------------------------------
// rrqt_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqt_front
    import rrqt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_ready,
    output t_cmd      o_cmd
);

    t_cmd r_q [QDEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_cmd;

    // Classify the incoming transaction
    always_comb begin
        w_cmd            = '0;
        w_cmd.item       = i_data;
        w_cmd.sweep      = (i_data.kind == K_RESERVE) || (i_data.kind == K_FORWARD);
        w_cmd.slot       = i_data.handle_in[8 +: SLOT_W];
        w_cmd.slot_ok    = (12'(i_data.handle_in[11:8]) < 12'(SLOTS));
        w_cmd.early_fail = 1'b0;
        w_cmd.early_st   = ST_OK;
        if (i_data.kind == K_RESERVE && !i_data.identity_present) begin
            w_cmd.early_fail = 1'b1;
            w_cmd.early_st   = ST_NO_ID;
        end else if (i_data.kind == K_RESERVE && i_data.endpoint_forbidden) begin
            w_cmd.early_fail = 1'b1;
            w_cmd.early_st   = ST_FORBID;
        end
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Push and pop the queue
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_valid && o_ready) r_wp <= r_wp + 1'b1;
            if (o_cmd_valid && i_cmd_ready) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_cmd_valid && i_cmd_ready);
        end
    end

endmodule

`default_nettype wire

>>> sv/rrqt_back.sv
// ----------------------------------------------------------------------------
// rrqt_back
// Sweeps the slot table one slot a cycle for reserve and forward, and carries out each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqt_back
    import rrqt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_per_id, r_per_grp, r_live;
    logic             r_free_ok;
    logic [SLOT_W-1:0] r_free;

    logic [SLOTS-1:0] r_valid;
    logic [7:0]  r_gen   [SLOTS];
    logic [63:0] r_sid   [SLOTS];
    logic [63:0] r_sgrp  [SLOTS];
    logic        r_sgp   [SLOTS];
    logic [47:0] r_sexp  [SLOTS];
    logic [47:0] r_slast [SLOTS];
    logic [39:0] r_sbyte [SLOTS];
    logic [15:0] r_sconn [SLOTS];
    logic [39:0] r_sblim [SLOTS];
    logic [15:0] r_sclim [SLOTS];

    logic [63:0] r_fsum;
    logic [31:0] r_asum;
    t_out        r_out;

    t_out        n_out;
    logic [63:0] n_fsum;
    logic [31:0] n_asum;

    logic [SLOT_W-1:0] w_i;
    logic [47:0] w_now;
    logic        w_drop, w_live;
    logic [48:0] w_exp_sum;
    logic [47:0] w_exp_new;
    logic [47:0] w_last_d;
    logic [SLOT_W-1:0] w_s;
    logic        w_match;
    logic [4:0]  w_cap;
    logic [40:0] w_bsum;
    logic [39:0] w_bsat;
    logic        w_fill, w_fwd_ok, w_add_wr, w_close_dec;

    assign w_i   = r_idx[SLOT_W-1:0];
    assign w_now = r_cmd.item.now;
    assign w_last_d = w_now - r_slast[w_i];
    assign w_drop = (r_sexp[w_i] <= w_now) ||
                    ((w_now > r_slast[w_i]) && (w_last_d > {16'd0, i_cfg.idle}));
    assign w_live = r_valid[w_i] && !w_drop;

    assign w_s     = r_cmd.slot;
    assign w_match = r_cmd.slot_ok && r_valid[w_s] &&
                     (r_gen[w_s] == r_cmd.item.handle_in[7:0]);
    assign w_cap   = (i_cfg.max_tot > 5'(SLOTS)) ? 5'(SLOTS) : i_cfg.max_tot;
    assign w_exp_sum = {1'b0, w_now} + {17'd0, i_cfg.ttl};
    assign w_exp_new = w_exp_sum[48] ? M48 : w_exp_sum[47:0];
    assign w_bsum  = {1'b0, r_sbyte[w_s]} + {1'b0, r_cmd.item.byte_count};
    assign w_bsat  = w_bsum[40] ? M40 : w_bsum[39:0];

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_data      = r_out;

    // Decide the result, the totals and the slot updates of the transaction
    always_comb begin
        n_out        = '0;
        n_out.status = ST_NOT_FOUND;
        n_fsum       = r_fsum;
        n_asum       = r_asum;
        w_fill       = 1'b0;
        w_fwd_ok     = 1'b0;
        w_add_wr     = 1'b0;
        w_close_dec  = 1'b0;
        case (r_cmd.item.kind)
            K_RESERVE: begin
                if (r_cmd.early_fail) begin
                    n_out.status = r_cmd.early_st;
                end else if (5'(r_per_id) >= i_cfg.max_id) begin
                    n_out.status = ST_ID_CAP;
                end else if (5'(r_per_grp) >= i_cfg.max_grp) begin
                    n_out.status = ST_GRP_CAP;
                end else if (5'(r_live) >= w_cap || !r_free_ok) begin
                    n_out.status = ST_TOT_CAP;
                end else begin
                    w_fill           = 1'b1;
                    n_out.status     = ST_OK;
                    n_out.handle_out = {4'(r_free), r_gen[r_free] + 8'd1};
                    n_out.expiry     = w_exp_new;
                end
            end
            K_FORWARD: begin
                if (w_match) begin
                    n_out.handle_out = {4'(w_s), r_gen[w_s]};
                    n_out.expiry     = r_sexp[w_s];
                    n_out.used_bytes = r_sbyte[w_s];
                    n_out.conn_count = r_sconn[w_s];
                    if (r_sexp[w_s] <= w_now) begin
                        n_out.status = ST_EXPIRED;
                    end else if (r_sconn[w_s] >= r_sclim[w_s]) begin
                        n_out.status = ST_CONN_CEIL;
                    end else if (w_bsum > {1'b0, r_sblim[w_s]}) begin
                        n_out.status = ST_BYTE_CEIL;
                    end else begin
                        w_fwd_ok         = 1'b1;
                        n_fsum           = r_fsum + {24'd0, r_cmd.item.byte_count};
                        if (r_asum != 32'hFFFF_FFFF) n_asum = r_asum + 32'd1;
                        n_out.status     = ST_OK;
                        n_out.used_bytes = w_bsum[39:0];
                        n_out.conn_count = r_sconn[w_s] + 16'd1;
                    end
                end
            end
            K_ADD: begin
                if (w_match) begin
                    n_out.status     = ST_OK;
                    n_out.handle_out = {4'(w_s), r_gen[w_s]};
                    n_out.expiry     = r_sexp[w_s];
                    n_out.conn_count = r_sconn[w_s];
                    n_out.used_bytes = r_sbyte[w_s];
                    if (r_cmd.item.byte_count != 40'd0) begin
                        w_add_wr         = 1'b1;
                        n_out.used_bytes = w_bsat;
                        n_fsum           = r_fsum + {24'd0, r_cmd.item.byte_count};
                    end
                end
            end
            K_CLOSE: begin
                if (w_match) begin
                    n_out.status     = ST_OK;
                    n_out.handle_out = {4'(w_s), r_gen[w_s]};
                    n_out.expiry     = r_sexp[w_s];
                    n_out.used_bytes = r_sbyte[w_s];
                    n_out.conn_count = r_sconn[w_s];
                    if (r_sconn[w_s] != 16'd0) begin
                        w_close_dec      = 1'b1;
                        n_out.conn_count = r_sconn[w_s] - 16'd1;
                        if (r_asum != 32'd0) n_asum = r_asum - 32'd1;
                    end
                end
            end
            K_LOOKUP: begin
                if (w_match) begin
                    n_out.status     = ST_OK;
                    n_out.handle_out = {4'(w_s), r_gen[w_s]};
                    n_out.expiry     = r_sexp[w_s];
                    n_out.used_bytes = r_sbyte[w_s];
                    n_out.conn_count = r_sconn[w_s];
                end
            end
            default: begin
            end
        endcase
        n_out.total_forwarded = n_fsum;
        n_out.active_forwards = n_asum;
    end

    // Sequence sweep, execute and hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_fsum  <= '0;
            r_asum  <= '0;
            for (int k = 0; k < SLOTS; k++) r_gen[k] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd     <= i_cmd;
                        r_idx     <= '0;
                        r_per_id  <= '0;
                        r_per_grp <= '0;
                        r_live    <= '0;
                        r_free_ok <= 1'b0;
                        r_free    <= '0;
                        r_state   <= i_cmd.sweep ? S_SCAN : S_EXEC;
                    end
                end
                // Drop stale slots and count live ones, one slot a cycle
                S_SCAN: begin
                    if (r_valid[w_i] && w_drop) r_valid[w_i] <= 1'b0;
                    if (w_live) begin
                        r_live <= r_live + 1'b1;
                        if (r_sid[w_i] == r_cmd.item.identity) r_per_id <= r_per_id + 1'b1;
                        if (r_cmd.item.group_present && r_sgp[w_i] &&
                            r_sgrp[w_i] == r_cmd.item.group)
                            r_per_grp <= r_per_grp + 1'b1;
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= w_i;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CNT_W'(SLOTS - 1)) r_state <= S_EXEC;
                end
                // Commit the result, the totals and the slot updates
                S_EXEC: begin
                    r_out   <= n_out;
                    r_fsum  <= n_fsum;
                    r_asum  <= n_asum;
                    r_state <= S_OUT;
                    if (w_fill) begin
                        r_valid[r_free] <= 1'b1;
                        r_sid[r_free]   <= r_cmd.item.identity;
                        r_sgrp[r_free]  <= r_cmd.item.group;
                        r_sgp[r_free]   <= r_cmd.item.group_present;
                        r_sexp[r_free]  <= w_exp_new;
                        r_slast[r_free] <= w_now;
                        r_sbyte[r_free] <= '0;
                        r_sconn[r_free] <= '0;
                        r_sblim[r_free] <= i_cfg.blimit;
                        r_sclim[r_free] <= i_cfg.climit;
                        r_gen[r_free]   <= r_gen[r_free] + 8'd1;
                    end
                    if (w_fwd_ok) begin
                        r_sbyte[w_s] <= w_bsum[39:0];
                        r_sconn[w_s] <= r_sconn[w_s] + 16'd1;
                        r_slast[w_s] <= w_now;
                    end
                    if (w_add_wr) begin
                        r_sbyte[w_s] <= w_bsat;
                        r_slast[w_s] <= w_now;
                    end
                    if (w_close_dec) r_sconn[w_s] <= r_sconn[w_s] - 16'd1;
                end
                // Hold the result until it is taken
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/rrqt_cfg.sv
// ----------------------------------------------------------------------------
// rrqt_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqt_cfg
    import rrqt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_index,
    input  wire logic [63:0] i_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    assign o_cfg = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_id  <= 5'd2;
            r_cfg.max_grp <= 5'd4;
            r_cfg.max_tot <= 5'd16;
            r_cfg.ttl     <= 32'd3600000;
            r_cfg.idle    <= 32'd300000;
            r_cfg.blimit  <= 40'd1073741824;
            r_cfg.climit  <= 16'd8;
        end else if (i_valid) begin
            case (i_index)
                R_MAX_ID:  r_cfg.max_id  <= i_wdata[4:0];
                R_MAX_GRP: r_cfg.max_grp <= i_wdata[4:0];
                R_MAX_TOT: r_cfg.max_tot <= i_wdata[4:0];
                R_TTL:     r_cfg.ttl     <= i_wdata[31:0];
                R_IDLE:    r_cfg.idle    <= i_wdata[31:0];
                R_BLIMIT:  r_cfg.blimit  <= i_wdata[39:0];
                R_CLIMIT:  r_cfg.climit  <= i_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/relay_reservation_quota_table_core.sv
// ----------------------------------------------------------------------------
// relay_reservation_quota_table_core
// Slot table of relay reservations with caps, ceilings and running totals.
// ----------------------------------------------------------------------------
// One transaction at a time is executed. Reserve and forward, rejected reserves
// included, sweep the 16 slots one per cycle before acting. Each transaction is
// queued in front, captured by the back end, swept if its kind needs it, then
// executed; the result is registered and held until taken, and only then does
// the back end take the next one. Add bytes, close, lookup and unknown kinds
// skip the sweep. A two-entry queue in front keeps accepting while the back end
// works; a result that is not taken holds the back end, and once the queue is
// full the input stalls. Configuration writes act at once, so write registers
// only while nothing is in flight. No clearing pass is needed after reset.
`default_nettype none

module relay_reservation_quota_table_core
    import rrqt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;

    assign o_cfg_ready = 1'b1;

    rrqt_cfg u_cfg (
        .i_clk, .i_rst_n,
        .i_valid(i_cfg_valid), .i_index(i_cfg_index), .i_wdata(i_cfg_wdata),
        .o_cfg(w_cfg)
    );

    rrqt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    rrqt_back u_back (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_data
    );

endmodule

`default_nettype wire

>>> sv/rrqt_checker.sv
// ----------------------------------------------------------------------------
// rrqt_checker
// Port-level checks of the quota table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "relay_reservation_quota_table_core_defines.svh"

module rrqt_checker
    import rrqt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    `RRQT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `RRQT_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_data.status <= ST_NOT_FOUND)
    `RRQT_ASSERT_IMP(a_fail_empty, i_clk, i_rst_n, o_valid && (o_data.status == ST_NO_ID || o_data.status == ST_NOT_FOUND || o_data.status == ST_TOT_CAP), o_data.handle_out == 12'd0 && o_data.conn_count == 16'd0)
    `RRQT_ASSERT_IMP(a_handle_slot, i_clk, i_rst_n, o_valid && o_data.status == ST_OK, 13'(o_data.handle_out[11:8]) < 13'(SLOTS))

endmodule

bind relay_reservation_quota_table_core rrqt_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);

`default_nettype wire

>>> tb/tb_relay_reservation_quota_table_core.sv
// ----------------------------------------------------------------------------
// tb_relay_reservation_quota_table_core
// Drives reserve, forward, add, close, lookup and unknown-kind transactions into
// the reservation table, predicts every result and compares it with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_relay_reservation_quota_table_core;
    import rrqt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;

    relay_reservation_quota_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    localparam int CYCLE_LIMIT = 600000;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow configuration and table
    logic [4:0]  sh_max_id, sh_max_grp, sh_max_tot;
    logic [31:0] sh_ttl, sh_idle;
    logic [39:0] sh_blimit;
    logic [15:0] sh_climit;

    logic        tab_valid [SLOTS];
    logic [63:0] tab_ident [SLOTS];
    logic [63:0] tab_group [SLOTS];
    logic        tab_gp    [SLOTS];
    logic [47:0] tab_exp   [SLOTS];
    logic [47:0] tab_last  [SLOTS];
    logic [39:0] tab_bytes [SLOTS];
    logic [15:0] tab_conns [SLOTS];
    logic [39:0] tab_blim  [SLOTS];
    logic [15:0] tab_clim  [SLOTS];
    logic [7:0]  tab_gen   [SLOTS];
    logic [63:0] fwd_sum;
    logic [31:0] act_sum;

    t_out  expected_results[$];
    int    mismatches;
    int    cycles;
    bit    quiet;           // no idling in the last part
    bit    hold_rx;         // long receiver hold-off
    logic [47:0] clock_ms;
    logic [11:0] live_handles[$];

    task automatic reset_shadow();
        sh_max_id = 5'd2; sh_max_grp = 5'd4; sh_max_tot = 5'd16;
        sh_ttl = 32'd3600000; sh_idle = 32'd300000;
        sh_blimit = 40'd1073741824; sh_climit = 16'd8;
        for (int i = 0; i < SLOTS; i++) begin
            tab_valid[i] = 1'b0; tab_gen[i] = 8'd0;
            tab_ident[i] = '0; tab_group[i] = '0; tab_gp[i] = 1'b0;
            tab_exp[i] = '0; tab_last[i] = '0; tab_bytes[i] = '0;
            tab_conns[i] = '0; tab_blim[i] = '0; tab_clim[i] = '0;
        end
        fwd_sum = '0; act_sum = '0;
    endtask

    task automatic shadow_config(input logic [2:0] idx, input logic [63:0] val);
        case (idx)
            R_MAX_ID:  sh_max_id  = val[4:0];
            R_MAX_GRP: sh_max_grp = val[4:0];
            R_MAX_TOT: sh_max_tot = val[4:0];
            R_TTL:     sh_ttl     = val[31:0];
            R_IDLE:    sh_idle    = val[31:0];
            R_BLIMIT:  sh_blimit  = val[39:0];
            R_CLIMIT:  sh_climit  = val[15:0];
            default: ;
        endcase
    endtask

    function automatic int lookup_slot(input logic [11:0] h);
        int s;
        s = int'(h[11:8]);
        if (s >= SLOTS || !tab_valid[s] || tab_gen[s] != h[7:0]) return -1;
        return s;
    endfunction

    // Drop slots past expiry or idle too long
    task automatic sweep_table(input logic [47:0] now);
        for (int i = 0; i < SLOTS; i++) begin
            if (!tab_valid[i]) continue;
            if (tab_exp[i] <= now) tab_valid[i] = 1'b0;
            else if (now > tab_last[i] && (now - tab_last[i]) > {16'd0, sh_idle})
                tab_valid[i] = 1'b0;
        end
    endtask

    // Compute the result of one transaction and advance the shadow table
    task automatic predict_result(input t_in it, output t_out r);
        int s;
        int free_slot;
        int per_id, per_grp, live, cap;
        logic [48:0] exp_sum;
        logic [40:0] bsum;
        r = '0;
        r.status = ST_NOT_FOUND;
        s = -1;
        case (it.kind)
            K_RESERVE: begin
                sweep_table(it.now);
                if (!it.identity_present) r.status = ST_NO_ID;
                else if (it.endpoint_forbidden) r.status = ST_FORBID;
                else begin
                    free_slot = -1; per_id = 0; per_grp = 0; live = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!tab_valid[i]) begin
                            if (free_slot < 0) free_slot = i;
                        end else begin
                            live++;
                            if (tab_ident[i] == it.identity) per_id++;
                            if (it.group_present && tab_gp[i] && tab_group[i] == it.group)
                                per_grp++;
                        end
                    end
                    cap = (int'(sh_max_tot) > SLOTS) ? SLOTS : int'(sh_max_tot);
                    if (per_id >= int'(sh_max_id)) r.status = ST_ID_CAP;
                    else if (per_grp >= int'(sh_max_grp)) r.status = ST_GRP_CAP;
                    else if (live >= cap || free_slot < 0) r.status = ST_TOT_CAP;
                    else begin
                        s = free_slot;
                        exp_sum = {1'b0, it.now} + {17'd0, sh_ttl};
                        tab_valid[s] = 1'b1;
                        tab_ident[s] = it.identity;
                        tab_group[s] = it.group;
                        tab_gp[s] = it.group_present;
                        tab_exp[s] = exp_sum[48] ? M48 : exp_sum[47:0];
                        tab_last[s] = it.now;
                        tab_bytes[s] = '0;
                        tab_conns[s] = '0;
                        tab_blim[s] = sh_blimit;
                        tab_clim[s] = sh_climit;
                        tab_gen[s] = tab_gen[s] + 8'd1;
                        r.status = ST_OK;
                    end
                end
            end
            K_FORWARD: begin
                sweep_table(it.now);
                s = lookup_slot(it.handle_in);
                if (s >= 0) begin
                    bsum = {1'b0, tab_bytes[s]} + {1'b0, it.byte_count};
                    if (tab_exp[s] <= it.now) r.status = ST_EXPIRED;
                    else if (tab_conns[s] >= tab_clim[s]) r.status = ST_CONN_CEIL;
                    else if (bsum > {1'b0, tab_blim[s]}) r.status = ST_BYTE_CEIL;
                    else begin
                        tab_bytes[s] = bsum[39:0];
                        tab_conns[s] = tab_conns[s] + 16'd1;
                        tab_last[s] = it.now;
                        fwd_sum = fwd_sum + {24'd0, it.byte_count};
                        if (act_sum != 32'hFFFF_FFFF) act_sum = act_sum + 32'd1;
                        r.status = ST_OK;
                    end
                end
            end
            K_ADD: begin
                s = lookup_slot(it.handle_in);
                if (s >= 0) begin
                    if (it.byte_count != 0) begin
                        bsum = {1'b0, tab_bytes[s]} + {1'b0, it.byte_count};
                        tab_bytes[s] = bsum[40] ? M40 : bsum[39:0];
                        tab_last[s] = it.now;
                        fwd_sum = fwd_sum + {24'd0, it.byte_count};
                    end
                    r.status = ST_OK;
                end
            end
            K_CLOSE: begin
                s = lookup_slot(it.handle_in);
                if (s >= 0) begin
                    if (tab_conns[s] > 0) begin
                        tab_conns[s] = tab_conns[s] - 16'd1;
                        if (act_sum > 0) act_sum = act_sum - 32'd1;
                    end
                    r.status = ST_OK;
                end
            end
            K_LOOKUP: begin
                s = lookup_slot(it.handle_in);
                if (s >= 0) r.status = ST_OK;
            end
            default: ;
        endcase
        if (s >= 0) begin
            r.handle_out = {s[3:0], tab_gen[s]};
            r.expiry = tab_exp[s];
            r.used_bytes = tab_bytes[s];
            r.conn_count = tab_conns[s];
        end
        r.total_forwarded = fwd_sum;
        r.active_forwards = act_sum;
        if (s >= 0 && it.kind == K_RESERVE && r.status == ST_OK)
            live_handles.insert(live_handles.size(), r.handle_out);
    endtask

    // Sender: offer one transaction, hold it until taken
    task automatic send_item(input t_in it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge i_clk);
        end
        i_data = it;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Predict, queue and send
    task automatic issue(input t_in it);
        t_out r;
        predict_result(it, r);
        expected_results.insert(expected_results.size(), r);
        send_item(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_index = idx;
        i_cfg_wdata = val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        shadow_config(idx, val);
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic t_in blank_item(input logic [2:0] k);
        t_in it;
        it = '0;
        it.kind = k;
        it.identity_present = 1'b1;
        it.now = clock_ms;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random transaction biased toward live handles and small id sets
    function automatic t_in random_item();
        t_in it;
        int pick;
        it = blank_item(K_RESERVE);
        pick = $urandom_range(0, 99);
        if (pick < 30) it.kind = K_RESERVE;
        else if (pick < 60) it.kind = K_FORWARD;
        else if (pick < 72) it.kind = K_ADD;
        else if (pick < 84) it.kind = K_CLOSE;
        else if (pick < 96) it.kind = K_LOOKUP;
        else it.kind = 3'($urandom_range(5, 7));
        it.identity = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 5));
        it.identity_present = ($urandom_range(0, 15) != 0);
        it.group = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 3));
        it.group_present = 1'($urandom_range(0, 1));
        it.endpoint_forbidden = ($urandom_range(0, 15) == 0);
        if (live_handles.size() != 0 && $urandom_range(0, 7) != 0)
            it.handle_in = live_handles[$urandom_range(0, live_handles.size() - 1)];
        else
            it.handle_in = 12'($urandom());
        case ($urandom_range(0, 7))
            0: it.byte_count = {$urandom(), 8'($urandom())};
            1: it.byte_count = '0;
            default: it.byte_count = 40'($urandom_range(0, 100000));
        endcase
        // advance the clock, sometimes a lot, sometimes backward
        case ($urandom_range(0, 15))
            0: clock_ms = clock_ms + 48'($urandom_range(0, 400000));
            1: clock_ms = clock_ms - 48'($urandom_range(0, 1000));
            default: clock_ms = clock_ms + 48'($urandom_range(0, 2000));
        endcase
        it.now = clock_ms;
        return it;
    endfunction

    // Receiver readiness: random stalls, quiet tail, and a long hold-off
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) i_ready = 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_ready = 1'b1;
            end else i_ready = 1'b1;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_data);
            end else begin
                e = expected_results.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d h=%h exp=%h b=%h c=%h tf=%h af=%h / act st=%0d h=%h exp=%h b=%h c=%h tf=%h af=%h",
                            e.status, e.handle_out, e.expiry, e.used_bytes, e.conn_count,
                            e.total_forwarded, e.active_forwards,
                            o_data.status, o_data.handle_out, o_data.expiry,
                            o_data.used_bytes, o_data.conn_count,
                            o_data.total_forwarded, o_data.active_forwards);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_relay_reservation_quota_table_core: FAIL");
            $finish;
        end
    end

    // Directed table: kind, handle, bytes, flags; expected status typed in
    typedef struct {
        logic [2:0]  kind;
        logic [63:0] ident;
        logic        idp;
        logic [63:0] grp;
        logic        gp;
        logic        forbid;
        logic [11:0] handle;
        logic [39:0] nbytes;
        logic [47:0] dt;
        logic [3:0]  st;
    } t_row;

    t_row rows[$];

    initial begin
        t_in it;
        t_out r;
        cycles = 0; mismatches = 0; quiet = 0; hold_rx = 0; clock_ms = 48'd1000;
        i_valid = 0; i_data = '0; i_cfg_valid = 0; i_cfg_index = R_MAX_ID; i_cfg_wdata = '0;
        i_rst_n = 0;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // lookup after reset, no identity, forbidden, then fill one identity
        rows = '{
            '{K_LOOKUP, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd0, ST_NOT_FOUND},
            '{K_RESERVE, 64'd7, 1'b0, 64'd0, 1'b0, 1'b0, 12'h000, 40'd0, 48'd1, ST_NO_ID},
            '{K_RESERVE, 64'd7, 1'b1, 64'd0, 1'b0, 1'b1, 12'h000, 40'd0, 48'd1, ST_FORBID},
            '{K_RESERVE, 64'd7, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0, 48'd1, ST_OK},
            '{K_RESERVE, 64'd7, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0, 48'd1, ST_OK},
            '{K_RESERVE, 64'd7, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0, 48'd1, ST_ID_CAP},
            '{K_RESERVE, 64'd8, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0, 48'd1, ST_OK},
            '{K_RESERVE, 64'd9, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0, 48'd1, ST_OK},
            '{K_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd3, 1'b1, 1'b0, 12'h000, 40'd0,
              48'd1, ST_GRP_CAP},
            '{K_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd3, 1'b0, 1'b0, 12'h000, 40'd0,
              48'd1, ST_OK},
            '{K_FORWARD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd100, 48'd1, ST_OK},
            '{K_FORWARD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'hFF_FFFF_FFFF, 48'd1,
              ST_BYTE_CEIL},
            '{K_ADD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'hFF_FFFF_FFFF, 48'd1, ST_OK},
            '{K_ADD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd1, ST_OK},
            '{K_CLOSE, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd1, ST_OK},
            '{K_CLOSE, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd1, ST_OK},
            '{K_LOOKUP, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h101, 40'd0, 48'd1, ST_OK},
            '{K_LOOKUP, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h102, 40'd0, 48'd1, ST_NOT_FOUND},
            '{K_LOOKUP, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'hF01, 40'd0, 48'd1, ST_NOT_FOUND},
            '{3'd5, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd1, ST_NOT_FOUND},
            '{3'd7, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd0, 48'd1, ST_NOT_FOUND},
            // idle span passes: forward on swept slot is not found
            '{K_FORWARD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h101, 40'd1, 48'd300001,
              ST_NOT_FOUND},
            '{K_FORWARD, 64'd0, 1'b1, 64'd0, 1'b0, 1'b0, 12'h001, 40'd1, 48'd1, ST_NOT_FOUND}
        };
        foreach (rows[k]) begin
            it = blank_item(rows[k].kind);
            it.identity = rows[k].ident;
            it.identity_present = rows[k].idp;
            it.group = rows[k].grp;
            it.group_present = rows[k].gp;
            it.endpoint_forbidden = rows[k].forbid;
            it.handle_in = rows[k].handle;
            it.byte_count = rows[k].nbytes;
            clock_ms = clock_ms + rows[k].dt;
            it.now = clock_ms;
            predict_result(it, r);
            if (r.status != rows[k].st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: table status %0d, predicted %0d", k, rows[k].st, r.status);
            end
            expected_results.insert(expected_results.size(), r);
            send_item(it);
        end
        drain();

        // Configuration phases, extremes included, then random traffic
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(R_MAX_ID, 64'd16); write_reg(R_MAX_GRP, 64'd16);
                    write_reg(R_MAX_TOT, 64'd16); write_reg(R_TTL, 64'hFFFF_FFFF);
                    write_reg(R_IDLE, 64'hFFFF_FFFF); write_reg(R_BLIMIT, 64'hFF_FFFF_FFFF);
                    write_reg(R_CLIMIT, 64'hFFFF);
                end
                1: begin
                    write_reg(R_MAX_ID, 64'd0); write_reg(R_MAX_GRP, 64'd0);
                    write_reg(R_MAX_TOT, 64'd0); write_reg(R_TTL, 64'd0);
                    write_reg(R_IDLE, 64'd0); write_reg(R_BLIMIT, 64'd0);
                    write_reg(R_CLIMIT, 64'd0);
                end
                default: begin
                    write_reg(R_MAX_ID, 64'($urandom_range(1, 16)));
                    write_reg(R_MAX_GRP, 64'($urandom_range(1, 16)));
                    write_reg(R_MAX_TOT, 64'($urandom_range(4, 31)));
                    write_reg(R_TTL, 64'($urandom_range(5000, 800000)));
                    write_reg(R_IDLE, 64'($urandom_range(2000, 400000)));
                    write_reg(R_BLIMIT, 64'($urandom_range(50000, 3000000)));
                    write_reg(R_CLIMIT, 64'($urandom_range(1, 12)));
                end
            endcase
            if (ph == 1) begin
                repeat (20) issue(random_item());
            end else begin
                // near-overflow clock in the first phase to hit saturation
                if (ph == 0) clock_ms = 48'hFFFF_FFF0_0000;
                if (ph == 2) clock_ms = 48'd5000000;
                if (ph == 3) begin
                    fork
                        begin
                            hold_rx = 1;
                            repeat (400) @(negedge i_clk);
                            hold_rx = 0;
                        end
                    join_none
                end
                if (ph == 5) quiet = 1;
                for (int n = 0; n < 170; n++) issue(random_item());
            end
            drain();
        end

        if (mismatches == 0) $display("tb_relay_reservation_quota_table_core: PASS");
        else $display("tb_relay_reservation_quota_table_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
